// ----- hw/rtl/hnks_pkg.sv -----
// Shared types, widths and helper functions for the nearest-key search block.
// Depends on nothing; every other file but hnks_ram imports it.
package hnks_pkg;

   localparam int TABLE_DEPTH   = 8192;
   localparam int FRACTION_BITS = 8;
   localparam int LAST_ROW_RESET = 6560;

   localparam int ROW_W     = $clog2(TABLE_DEPTH);
   localparam int FIELD_ROW_W = 13;
   localparam int KEY_W     = 9;
   localparam int QUERY_W   = 17;
   localparam int NUM_COLS  = 4;
   localparam int COL_W     = $clog2(NUM_COLS);
   localparam int SCALED_W  = KEY_W + FRACTION_BITS;
   localparam int DIFF_W    = ((SCALED_W > QUERY_W) ? SCALED_W : QUERY_W) + 2;
   localparam int WORD_W    = KEY_W * NUM_COLS;

   typedef logic [KEY_W-1:0]               key_type;
   typedef key_type [NUM_COLS-1:0]         row_word_type;
   typedef logic [QUERY_W-1:0]             query_type;
   typedef query_type [NUM_COLS-1:0]       query_vec_type;
   typedef logic [ROW_W-1:0]               row_index_type;
   typedef logic [COL_W-1:0]               col_type;
   typedef logic signed [DIFF_W-1:0]       diff_type;

   // Result of the shared compare unit.
   typedef struct packed {
      logic above;
      logic take_front;
      logic equal;
   } cmp_result_type;

   // Status the sequencer reports to the top level.
   typedef struct packed {
      logic          idle;
      logic          done;
      row_index_type nearest_row;
   } seq_status_type;

   // Column 0 is the view elevation, which sits in the top slot of a row word.
   function automatic key_type col_key(input row_word_type word, input col_type col);
      col_type slot;
      slot = col_type'(NUM_COLS - 1) - col;
      return word[slot];
   endfunction

   // Fixed-point value truncated toward zero to whole degrees.
   function automatic diff_type trunc_whole(input diff_type v);
      diff_type mag;
      mag = (v < 0) ? -v : v;
      mag = mag >>> FRACTION_BITS;
      return (v < 0) ? -mag : mag;
   endfunction

endpackage

// ----- hw/rtl/hnks_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hnks_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/hnks_cmp.sv -----
// Shared compare unit: key against query angle, nearer-side decision and key equality.
// Depends on hnks_pkg.
module hnks_cmp
   import hnks_pkg::*;
(
   input  key_type        cur_key,
   input  key_type        ref_key,
   input  query_type      query,
   output cmp_result_type result
);

   diff_type cur_s;
   diff_type ref_s;
   diff_type q_s;
   diff_type upper_dist;
   diff_type lower_dist;

   assign cur_s = diff_type'(cur_key) <<< FRACTION_BITS;
   assign ref_s = diff_type'(ref_key) <<< FRACTION_BITS;
   assign q_s   = diff_type'(query);

   // The reference key is the upper neighbor, the current key the lower one.
   assign upper_dist = trunc_whole(ref_s - q_s);
   assign lower_dist = trunc_whole(q_s - cur_s);

   assign result.above      = cur_s > q_s;
   assign result.take_front = upper_dist <= lower_dist;
   assign result.equal      = cur_key == ref_key;

endmodule

// ----- hw/rtl/hnks_seq.sv -----
// Search sequencer: walks the table one row per read, column by column.
// Depends on hnks_pkg and hnks_cmp.
module hnks_seq
   import hnks_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  query_vec_type   query,
   input  row_index_type   first_back,
   input  logic            out_free,
   output row_index_type   rd_addr,
   input  row_word_type    rd_data,
   output seq_status_type  status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_LOW_RD,
      S_LOW_EV,
      S_RUN_RD,
      S_RUN_EV,
      S_NEXT,
      S_DONE
   } state_type;

   state_type      state_ff, state_in;
   row_index_type  front_ff, front_in;
   row_index_type  back_ff, back_in;
   row_index_type  p_ff, p_in;
   col_type        col_ff, col_in;
   key_type        ref_key_ff, ref_key_in;
   logic           fwd_ff, fwd_in;
   query_vec_type  q_ff, q_in;

   key_type        cur_key;
   cmp_result_type cmp;
   row_index_type  p_dec;
   row_index_type  step;

   assign cur_key = col_key(rd_data, col_ff);
   assign p_dec   = p_ff - 1'b1;
   assign step    = fwd_ff ? (p_ff + 1'b1) : p_dec;

   hnks_cmp u_cmp (
      .cur_key (cur_key),
      .ref_key (ref_key_ff),
      .query   (q_ff[col_ff]),
      .result  (cmp)
   );

   always_comb begin
      state_in   = state_ff;
      front_in   = front_ff;
      back_in    = back_ff;
      p_in       = p_ff;
      col_in     = col_ff;
      ref_key_in = ref_key_ff;
      fwd_in     = fwd_ff;
      q_in       = q_ff;
      rd_addr    = p_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               q_in     = query;
               front_in = '0;
               back_in  = first_back;
               p_in     = '0;
               col_in   = '0;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            ref_key_in = cur_key;
            if (!cmp.above && (p_ff < back_ff)) begin
               p_in     = p_ff + 1'b1;
               state_in = S_SCAN_RD;
            end else if (cmp.above && (p_ff != '0)) begin
               state_in = S_LOW_RD;
            end else if (cmp.above) begin
               // First key above sits at row 0: no lower neighbor, keep the front.
               front_in = p_ff;
               fwd_in   = 1'b1;
               if (p_ff < back_ff) begin
                  state_in = S_RUN_RD;
               end else begin
                  back_in  = p_ff;
                  state_in = S_NEXT;
               end
            end else begin
               fwd_in = 1'b0;
               if (p_ff > front_ff) begin
                  state_in = S_RUN_RD;
               end else begin
                  front_in = p_ff;
                  state_in = S_NEXT;
               end
            end
         end
         S_LOW_RD: begin
            rd_addr  = p_dec;
            state_in = S_LOW_EV;
         end
         S_LOW_EV: begin
            if (cmp.take_front) begin
               front_in = p_ff;
               fwd_in   = 1'b1;
               if (p_ff < back_ff) begin
                  state_in = S_RUN_RD;
               end else begin
                  back_in  = p_ff;
                  state_in = S_NEXT;
               end
            end else begin
               p_in       = p_dec;
               back_in    = p_dec;
               ref_key_in = cur_key;
               fwd_in     = 1'b0;
               if (p_dec > front_ff) begin
                  state_in = S_RUN_RD;
               end else begin
                  front_in = p_dec;
                  state_in = S_NEXT;
               end
            end
         end
         S_RUN_RD: begin
            rd_addr  = step;
            state_in = S_RUN_EV;
         end
         S_RUN_EV: begin
            if (cmp.equal) begin
               p_in = step;
               if (fwd_ff) begin
                  if (step < back_ff) begin
                     state_in = S_RUN_RD;
                  end else begin
                     back_in  = step;
                     state_in = S_NEXT;
                  end
               end else begin
                  if (step > front_ff) begin
                     state_in = S_RUN_RD;
                  end else begin
                     front_in = step;
                     state_in = S_NEXT;
                  end
               end
            end else begin
               if (fwd_ff) begin
                  back_in = p_ff;
               end else begin
                  front_in = p_ff;
               end
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (col_ff == col_type'(NUM_COLS - 1)) begin
               state_in = S_DONE;
            end else begin
               col_in   = col_ff + 1'b1;
               p_in     = front_ff;
               state_in = S_SCAN_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      front_ff   <= front_in;
      back_ff    <= back_in;
      p_ff       <= p_in;
      col_ff     <= col_in;
      ref_key_ff <= ref_key_in;
      fwd_ff     <= fwd_in;
      q_ff       <= q_in;
   end

   assign status.idle        = state_ff == S_IDLE;
   assign status.done        = state_ff == S_DONE;
   assign status.nearest_row = back_ff;

endmodule

// ----- hw/rtl/hierarchical_nearest_key_search.sv -----
// Nearest-key search over a four-column angle table held in one RAM.
// A load writes its row into the table on the accepting edge. A query reads one row at a time
// (one RAM read port, registered data), with a read state and an evaluate state per row,
// and searches column by column before its result word goes into the result register.
// Throughput: one word in work at a time; req_stall is high meanwhile. Reset clears the
// sequencer and the result valid and sets last_row to 6560; table contents stay undefined.
module hierarchical_nearest_key_search
   import hnks_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [FIELD_ROW_W-1:0] req_row,
   input  logic [KEY_W-1:0]       req_key_view_elev,
   input  logic [KEY_W-1:0]       req_key_view_azim,
   input  logic [KEY_W-1:0]       req_key_light_elev,
   input  logic [KEY_W-1:0]       req_key_light_azim,
   input  logic [QUERY_W-1:0]     req_query_view_elev,
   input  logic [QUERY_W-1:0]     req_query_view_azim,
   input  logic [QUERY_W-1:0]     req_query_light_elev,
   input  logic [QUERY_W-1:0]     req_query_light_azim,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [FIELD_ROW_W-1:0] rsp_nearest_row,
   input  logic                   csr_wr_en,
   input  logic [FIELD_ROW_W-1:0] csr_wr_data
);

   logic [FIELD_ROW_W-1:0] last_row_ff;
   logic                   rsp_valid_ff;
   logic [FIELD_ROW_W-1:0] rsp_nearest_row_ff;

   seq_status_type status;
   logic           accept;
   logic           load_wr;
   logic           start;
   logic           out_free;
   row_index_type  first_back;
   row_index_type  rd_addr;
   row_word_type   rd_data;
   row_word_type   wr_word;
   query_vec_type  query;

   // The block takes a new word only while the sequencer is idle. A finished result
   // may still sit in the result register then, so loads and queries keep coming in.
   assign req_stall = !status.idle;
   assign accept    = req_valid && !req_stall;

   // A load writes its row straight into the table on the accepting edge; rows at or
   // beyond the table depth are dropped.
   assign load_wr = accept && !req_action && (32'(req_row) < TABLE_DEPTH);
   assign start   = accept && req_action;

   assign wr_word = {req_key_view_elev, req_key_view_azim,
                     req_key_light_elev, req_key_light_azim};
   // The sequencer indexes the query vector by column, and column 0 is the view
   // elevation, so the view elevation goes into element 0.
   assign query   = {req_query_light_azim, req_query_light_elev,
                     req_query_view_azim, req_query_view_elev};

   // The search range starts at [0, last_row], with last_row saturated to the table.
   assign first_back = (32'(last_row_ff) >= TABLE_DEPTH) ? row_index_type'(TABLE_DEPTH - 1)
                                                        : row_index_type'(last_row_ff);

   // The result register frees up in the same cycle that its word is taken.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   hnks_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (row_index_type'(req_row)),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hnks_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .query      (query),
      .first_back (first_back),
      .out_free   (out_free),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .status     (status)
   );

   // Configuration register. The range of a query is taken from it when the query
   // starts; the host must change it only while idle, which the block does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_row_ff <= FIELD_ROW_W'(LAST_ROW_RESET);
      end else if (csr_wr_en) begin
         last_row_ff <= csr_wr_data;
      end
   end

   // Result register. The sequencer holds in its done state until this register is
   // free, so a word is never overwritten before it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (status.done && out_free) begin
         rsp_nearest_row_ff <= FIELD_ROW_W'(status.nearest_row);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_nearest_row = rsp_nearest_row_ff;

endmodule
